@@ hw/rtl/lfdt_pkg.sv @@
// ----------------------------------------------------------------------------
// lfdt_pkg
// Types and constants shared by the leaflet flip dwell tracker.
// ----------------------------------------------------------------------------
package lfdt_pkg;

  // payload field widths
  localparam int unsigned SlotFieldW  = 12;
  localparam int unsigned TypeFieldW  = 4;
  localparam int unsigned DistW       = 16;
  localparam int unsigned LimitW      = 15;
  localparam int unsigned FramesW     = 10;
  localparam int unsigned DwellW      = 12;
  localparam int unsigned CountW      = 32;

  // configuration port
  localparam int unsigned CfgIdxW     = 8;
  localparam int unsigned CfgDataW    = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSpatialLimit = 8'd0,
    CfgDwellFrames  = 8'd1
  } lfdt_cfg_idx_e;

  localparam logic [LimitW-1:0]  LimitReset  = 15'd384;
  localparam logic [FramesW-1:0] FramesReset = 10'd10;

  // dwell counter bound
  localparam logic signed [DwellW:0] DwellMax = 13'sd1024;
  localparam logic signed [DwellW:0] DwellMin = -13'sd1024;

  // shift used when reducing an index modulo a parameter
  localparam int unsigned RecipSh = 28;

  typedef enum logic [1:0] {
    StClear,
    StIdle,
    StRead,
    StWrite
  } lfdt_state_e;

endpackage

@@ hw/rtl/lfdt_ram.sv @@
// ----------------------------------------------------------------------------
// lfdt_ram
// Generic simple dual-port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module lfdt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/leaflet_flip_dwell_tracker.sv @@
// ----------------------------------------------------------------------------
// leaflet_flip_dwell_tracker
// Per-slot dwell counters with spatial and temporal hysteresis, per-type
// saturating flip counts.
// ----------------------------------------------------------------------------
// Usage:
//   A sample (lipid_slot_i, lipid_type_i, signed_distance_i) is taken when
//   start_i is high and busy_o is low. Its result appears on the result ports
//   for one cycle with done_o high, after the StRead and StWrite states; the
//   receiver must take it then. A new sample can be taken in the cycle done_o
//   is high. Each sample goes through read of the dwell and count memories,
//   counter update with dwell write-back, then count update and write-back.
//   Each sample finishes its writes before the next is taken.
//   The configuration channel (cfg_valid_i / cfg_ready_o) is always ready;
//   write it only while the block is idle. Unknown indexes are dropped.
//   After reset the dwell memory is swept to zero, one slot per cycle, with
//   busy_o high; flip counts are cleared at once through per-type valid bits.
//   Registers return to 1.5 nm and 10 frames.
// ----------------------------------------------------------------------------
module leaflet_flip_dwell_tracker
  import lfdt_pkg::*;
#(
  parameter int unsigned LIPID_SLOTS = 4096,
  parameter int unsigned LIPID_KINDS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // sample channel
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic [SlotFieldW-1:0]      lipid_slot_i,
  input  logic [TypeFieldW-1:0]      lipid_type_i,
  input  logic signed [DistW-1:0]    signed_distance_i,
  // result channel
  output logic                       done_o,
  output logic                       flip_to_upper_o,
  output logic                       flip_to_lower_o,
  output logic signed [DwellW-1:0]   dwell_value_o,
  output logic [CountW-1:0]          count_to_upper_o,
  output logic [CountW-1:0]          count_to_lower_o,
  // configuration channel
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CfgIdxW-1:0]         cfg_index_i,
  input  logic [CfgDataW-1:0]        cfg_data_i
);

  localparam int unsigned SlotAw = (LIPID_SLOTS > 1) ? $clog2(LIPID_SLOTS) : 1;
  localparam int unsigned TypeAw = (LIPID_KINDS > 1) ? $clog2(LIPID_KINDS) : 1;
  localparam int unsigned SlotProdW = SlotFieldW + RecipSh + 1;
  localparam int unsigned TypeProdW = TypeFieldW + RecipSh + 1;
  localparam longint unsigned SlotRecip =
    ((64'd1 << RecipSh) + LIPID_SLOTS - 1) / LIPID_SLOTS;
  localparam longint unsigned TypeRecip =
    ((64'd1 << RecipSh) + LIPID_KINDS - 1) / LIPID_KINDS;

  lfdt_state_e state_q, state_d;

  logic [LimitW-1:0]        limit_q;
  logic [FramesW-1:0]       frames_q;
  logic [SlotAw-1:0]        clr_cnt_q;
  logic [SlotAw-1:0]        slot_q;
  logic [TypeAw-1:0]        type_q;
  logic signed [DistW-1:0]  dist_q;
  logic [LIPID_KINDS-1:0]   type_vld_q;
  logic signed [DwellW-1:0] dwell_q;
  logic                     up_q, dn_q;

  logic [SlotAw-1:0]        slot_idx;
  logic [TypeAw-1:0]        type_idx;
  logic                     accept;

  // ---------------------------------------------------------------------------
  // index wrap modulo the parameters (reciprocal multiply, exact for 12 bits)
  // ---------------------------------------------------------------------------
  if (LIPID_SLOTS >= (1 << SlotFieldW)) begin : g_slot_wide
    assign slot_idx = SlotAw'(lipid_slot_i);
  end else begin : g_slot_mod
    logic [SlotProdW-1:0]    slot_prod;
    logic [SlotFieldW-1:0]   slot_quo;
    logic [2*SlotFieldW-1:0] slot_qm;
    logic [SlotFieldW-1:0]   slot_rem;
    always_comb begin
      slot_prod = SlotProdW'(lipid_slot_i) * SlotProdW'(SlotRecip);
      slot_quo  = slot_prod[RecipSh +: SlotFieldW];
      slot_qm   = (2*SlotFieldW)'(slot_quo) * (2*SlotFieldW)'(LIPID_SLOTS);
      slot_rem  = lipid_slot_i - slot_qm[SlotFieldW-1:0];
    end
    assign slot_idx = slot_rem[SlotAw-1:0];
  end

  if (LIPID_KINDS >= (1 << TypeFieldW)) begin : g_type_wide
    assign type_idx = TypeAw'(lipid_type_i);
  end else begin : g_type_mod
    logic [TypeProdW-1:0]    type_prod;
    logic [TypeFieldW-1:0]   type_quo;
    logic [2*TypeFieldW-1:0] type_qm;
    logic [TypeFieldW-1:0]   type_rem;
    always_comb begin
      type_prod = TypeProdW'(lipid_type_i) * TypeProdW'(TypeRecip);
      type_quo  = type_prod[RecipSh +: TypeFieldW];
      type_qm   = (2*TypeFieldW)'(type_quo) * (2*TypeFieldW)'(LIPID_KINDS);
      type_rem  = lipid_type_i - type_qm[TypeFieldW-1:0];
    end
    assign type_idx = type_rem[TypeAw-1:0];
  end

  // ---------------------------------------------------------------------------
  // memories
  // ---------------------------------------------------------------------------
  logic                     dwell_we, dwell_re;
  logic [SlotAw-1:0]        dwell_waddr;
  logic [DwellW-1:0]        dwell_wdata;
  logic signed [DwellW-1:0] dwell_rdata;
  logic                     cnt_we, cnt_re;
  logic [2*CountW-1:0]      cnt_wdata;
  logic [2*CountW-1:0]      cnt_rdata;

  lfdt_ram #(
    .WIDTH (DwellW),
    .DEPTH (LIPID_SLOTS)
  ) u_dwell_ram (
    .clk_i   (clk_i),
    .we_i    (dwell_we),
    .waddr_i (dwell_waddr),
    .wdata_i (dwell_wdata),
    .re_i    (dwell_re),
    .raddr_i (slot_idx),
    .rdata_o (dwell_rdata)
  );

  lfdt_ram #(
    .WIDTH (2*CountW),
    .DEPTH (LIPID_KINDS)
  ) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (type_q),
    .wdata_i (cnt_wdata),
    .re_i    (cnt_re),
    .raddr_i (type_idx),
    .rdata_o (cnt_rdata)
  );

  // ---------------------------------------------------------------------------
  // dwell counter update
  // ---------------------------------------------------------------------------
  logic signed [DwellW:0]  c_cur, c_upd, c_nxt, t_s;
  logic signed [DistW:0]   d_s, lim_s;
  logic                    d_pos, d_neg, flip_up, flip_dn;

  always_comb begin
    c_cur = (DwellW+1)'(dwell_rdata);
    t_s   = $signed({3'b000, frames_q});
    d_s   = (DistW+1)'(dist_q);
    lim_s = $signed({2'b00, limit_q});
    d_pos = d_s > 0;
    d_neg = d_s < 0;
    c_upd = c_cur;
    if (d_s > lim_s) begin
      if (c_cur > t_s) c_upd = c_cur;
      else if (c_cur > 0) c_upd = c_cur + 13'sd1;
      else if (c_cur <= -t_s) c_upd = 13'sd1;
      else c_upd = t_s + 13'sd1;
    end else if (d_pos) begin
      if (c_cur > t_s) c_upd = c_cur;
      else if (c_cur > 0) c_upd = c_cur + 13'sd1;
      else if (c_cur <= -t_s) c_upd = c_cur;
      else c_upd = t_s + 13'sd1;
    end else if (d_s < -lim_s) begin
      if (c_cur >= t_s) c_upd = -13'sd1;
      else if (c_cur > 0) c_upd = -t_s - 13'sd1;
      else if (c_cur < -t_s) c_upd = c_cur;
      else if (c_cur < 0) c_upd = c_cur - 13'sd1;
      else c_upd = -t_s - 13'sd1;
    end else if (d_neg) begin
      if (c_cur >= t_s) c_upd = c_cur;
      else if (c_cur > 0) c_upd = -t_s - 13'sd1;
      else if (c_cur < -t_s) c_upd = c_cur;
      else if (c_cur < 0) c_upd = c_cur - 13'sd1;
      else c_upd = -t_s - 13'sd1;
    end
    if (c_upd > DwellMax) c_nxt = DwellMax;
    else if (c_upd < DwellMin) c_nxt = DwellMin;
    else c_nxt = c_upd;
    flip_up = (c_nxt == t_s) && d_pos;
    flip_dn = !flip_up && (c_nxt == -t_s) && d_neg;
  end

  // ---------------------------------------------------------------------------
  // flip count update
  // ---------------------------------------------------------------------------
  logic [CountW-1:0] up_cur, dn_cur, up_nxt, dn_nxt;

  always_comb begin
    // a type never written reads as zero
    up_cur = type_vld_q[type_q] ? cnt_rdata[2*CountW-1:CountW] : '0;
    dn_cur = type_vld_q[type_q] ? cnt_rdata[CountW-1:0] : '0;
    up_nxt = (up_q && (up_cur != '1)) ? up_cur + 1'b1 : up_cur;
    dn_nxt = (dn_q && (dn_cur != '1)) ? dn_cur + 1'b1 : dn_cur;
    cnt_wdata = {up_nxt, dn_nxt};
  end

  // ---------------------------------------------------------------------------
  // control
  // ---------------------------------------------------------------------------
  assign accept = start_i && (state_q == StIdle);

  always_comb begin
    state_d     = state_q;
    dwell_we    = 1'b0;
    dwell_re    = 1'b0;
    dwell_waddr = slot_q;
    dwell_wdata = c_nxt[DwellW-1:0];
    cnt_we      = 1'b0;
    cnt_re      = 1'b0;
    case (state_q)
      StClear: begin
        dwell_we    = 1'b1;
        dwell_waddr = clr_cnt_q;
        dwell_wdata = '0;
        if (clr_cnt_q == SlotAw'(LIPID_SLOTS - 1)) state_d = StIdle;
      end
      StIdle: begin
        if (start_i) begin
          dwell_re = 1'b1;
          cnt_re   = 1'b1;
          state_d  = StRead;
        end
      end
      StRead: begin
        dwell_we = 1'b1;
        state_d  = StWrite;
      end
      StWrite: begin
        cnt_we  = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StClear;
      clr_cnt_q  <= '0;
      limit_q    <= LimitReset;
      frames_q   <= FramesReset;
      type_vld_q <= '0;
      done_o     <= 1'b0;
    end else begin
      state_q <= state_d;
      done_o  <= (state_q == StWrite);
      if (state_q == StClear) clr_cnt_q <= clr_cnt_q + 1'b1;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CfgSpatialLimit: limit_q  <= cfg_data_i[LimitW-1:0];
          CfgDwellFrames:  frames_q <= cfg_data_i[FramesW-1:0];
          default: ;
        endcase
      end
      if (cnt_we) type_vld_q[type_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      slot_q <= slot_idx;
      type_q <= type_idx;
      dist_q <= signed_distance_i;
    end
    if (state_q == StRead) begin
      dwell_q <= c_nxt[DwellW-1:0];
      up_q    <= flip_up;
      dn_q    <= flip_dn;
    end
    if (state_q == StWrite) begin
      flip_to_upper_o  <= up_q;
      flip_to_lower_o  <= dn_q;
      dwell_value_o    <= dwell_q;
      count_to_upper_o <= up_nxt;
      count_to_lower_o <= dn_nxt;
    end
  end

  assign busy_o      = (state_q != StIdle);
  assign cfg_ready_o = 1'b1;

`ifndef SYNTHESIS
  a_done_after_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == StWrite))
    else $error("result strobe without a count write-back");

  a_accept_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (state_q == StRead))
    else $error("accepted sample did not start a memory read");

  a_one_direction: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(flip_to_upper_o && flip_to_lower_o))
    else $error("flip counted in both directions");

  a_dwell_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (dwell_value_o >= -12'sd1024) && (dwell_value_o <= 12'sd1024))
    else $error("dwell counter out of range");

  a_up_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && flip_to_upper_o) |-> (count_to_upper_o != '0))
    else $error("upper flip without a count");
`endif

endmodule

@@ tb/leaflet_flip_dwell_tracker_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// leaflet_flip_dwell_tracker_test
// Self-checking bench for the leaflet flip dwell tracker. A short table of
// hand-picked samples and register writes goes first, then constrained-ish
// random lipid trajectories under several threshold and dwell settings. Every
// result is compared against an in-bench tracker of dwell counters and flip
// counts, or against the values typed into its table row.
// ----------------------------------------------------------------------------
module leaflet_flip_dwell_tracker_test;
  import lfdt_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgUnused = 8'hFF;

  typedef struct packed {
    logic                     up;
    logic                     dn;
    logic signed [DwellW-1:0] dwell;
    logic [CountW-1:0]        cnt_up;
    logic [CountW-1:0]        cnt_dn;
  } flip_result_t;

  typedef enum logic {RowSample, RowWrite} row_kind_e;

  typedef struct {
    row_kind_e                kind;
    logic [CfgIdxW-1:0]       idx;
    logic [CfgDataW-1:0]      data;
    logic [SlotFieldW-1:0]    slot;
    logic [TypeFieldW-1:0]    ltype;
    logic signed [DistW-1:0]  distance;
    bit                       typed;
    flip_result_t             res;
  } stim_row_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     start_i = 1'b0;
  logic                     busy_o;
  logic [SlotFieldW-1:0]    lipid_slot_i = '0;
  logic [TypeFieldW-1:0]    lipid_type_i = '0;
  logic signed [DistW-1:0]  signed_distance_i = '0;
  logic                     done_o;
  logic                     flip_to_upper_o;
  logic                     flip_to_lower_o;
  logic signed [DwellW-1:0] dwell_value_o;
  logic [CountW-1:0]        count_to_upper_o;
  logic [CountW-1:0]        count_to_lower_o;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [CfgIdxW-1:0]       cfg_index_i = '0;
  logic [CfgDataW-1:0]      cfg_data_i = '0;

  leaflet_flip_dwell_tracker DUT (
    .clk_i,
    .rst_ni,
    .start_i,
    .busy_o,
    .lipid_slot_i,
    .lipid_type_i,
    .signed_distance_i,
    .done_o,
    .flip_to_upper_o,
    .flip_to_lower_o,
    .dwell_value_o,
    .count_to_upper_o,
    .count_to_lower_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  always #6 clk_i = ~clk_i;

  // tracker state as the block should hold it
  int                  dwell_mem [4096];
  logic [CountW-1:0]   up_flips [16];
  logic [CountW-1:0]   down_flips [16];
  logic [LimitW-1:0]   model_limit = LimitReset;
  logic [FramesW-1:0]  model_frames = FramesReset;

  flip_result_t        pending_results [$];
  flip_result_t        expected_now;
  stim_row_t           directed_rows [$];
  int                  slot_pool [8];
  int                  type_pool [8];
  int                  n_errors = 0;
  int                  n_results = 0;
  int                  n_up = 0;
  int                  n_dn = 0;
  int                  n_writes = 0;

  initial begin
    foreach (dwell_mem[i]) dwell_mem[i] = 0;
    foreach (up_flips[i]) begin
      up_flips[i] = '0;
      down_flips[i] = '0;
    end
  end

  function automatic flip_result_t track_sample(input logic [SlotFieldW-1:0] slot,
                                                input logic [TypeFieldW-1:0] ltype,
                                                input logic signed [DistW-1:0] distance);
    int d, lim, t, c;
    flip_result_t r;
    d = int'(distance);
    lim = int'(model_limit);
    t = int'(model_frames);
    c = dwell_mem[slot];
    if (d > lim) begin
      if (c > t) begin
      end else if (c > 0) begin
        c++;
      end else if (c <= -t) begin
        c = 1;
      end else begin
        c = t + 1;
      end
    end else if (d > 0) begin
      if (c > t || (c <= -t && c <= 0)) begin
      end else if (c > 0) begin
        c++;
      end else begin
        c = t + 1;
      end
    end else if (d < 0) begin
      // below the limit a settled upper lipid restarts at -1, in the zone it stays
      if (c >= t) begin
        if (d < -lim) c = -1;
      end else if (c > 0) begin
        c = -t - 1;
      end else if (c < -t) begin
      end else if (c < 0) begin
        c--;
      end else begin
        c = -t - 1;
      end
    end
    if (c > 1024) c = 1024;
    if (c < -1024) c = -1024;
    dwell_mem[slot] = c;
    r = '0;
    if (c == t && d > 0) begin
      r.up = 1'b1;
      if (up_flips[ltype] != '1) up_flips[ltype] = up_flips[ltype] + 1;
    end else if (c == -t && d < 0) begin
      r.dn = 1'b1;
      if (down_flips[ltype] != '1) down_flips[ltype] = down_flips[ltype] + 1;
    end
    r.dwell = c[DwellW-1:0];
    r.cnt_up = up_flips[ltype];
    r.cnt_dn = down_flips[ltype];
    return r;
  endfunction

  function automatic void add_sample(input int slot, input int ltype, input int distance);
    stim_row_t row;
    row.kind = RowSample;
    row.idx = '0;
    row.data = '0;
    row.slot = SlotFieldW'(slot);
    row.ltype = TypeFieldW'(ltype);
    row.distance = DistW'(distance);
    row.typed = 1'b0;
    row.res = '0;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_typed(input int slot, input int ltype, input int distance,
                                    input bit up, input bit dn, input int dwell,
                                    input int cu, input int cd);
    stim_row_t row;
    row.kind = RowSample;
    row.idx = '0;
    row.data = '0;
    row.slot = SlotFieldW'(slot);
    row.ltype = TypeFieldW'(ltype);
    row.distance = DistW'(distance);
    row.typed = 1'b1;
    row.res.up = up;
    row.res.dn = dn;
    row.res.dwell = DwellW'(dwell);
    row.res.cnt_up = CountW'(cu);
    row.res.cnt_dn = CountW'(cd);
    directed_rows.push_back(row);
  endfunction

  function automatic void add_write(input logic [CfgIdxW-1:0] idx,
                                    input logic [CfgDataW-1:0] data);
    stim_row_t row;
    row = '{kind: RowWrite, idx: idx, data: data, slot: '0, ltype: '0, distance: '0,
            typed: 1'b0, res: '0};
    directed_rows.push_back(row);
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("%0t mismatch in %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    n_errors++;
  endtask

  // called at a falling edge, returns at a falling edge; start_i stays high
  task automatic send_sample(input int slot, input int ltype, input int distance,
                             input int idle_pct, input bit typed,
                             input flip_result_t typed_res);
    flip_result_t predicted;
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i <= 1'b1;
    lipid_slot_i <= SlotFieldW'(slot);
    lipid_type_i <= TypeFieldW'(ltype);
    signed_distance_i <= DistW'(distance);
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    predicted = track_sample(SlotFieldW'(slot), TypeFieldW'(ltype), DistW'(distance));
    pending_results.push_back(typed ? typed_res : predicted);
    @(negedge clk_i);
  endtask

  task automatic quiesce();
    start_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CfgSpatialLimit: model_limit = data[LimitW-1:0];
      CfgDwellFrames:  model_frames = data[FramesW-1:0];
      default: ;
    endcase
    n_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // mostly runs of one lipid on one side, with single random samples between
  task automatic random_phase(input int n_items, input int idle_pct);
    int i, run_left, k, sgn, lim, hi, mag, pick, cap;
    run_left = 0;
    k = 0;
    sgn = 0;
    for (i = 0; i < n_items; i++) begin
      if (run_left == 0 && $urandom_range(99) < 12) begin
        send_sample($urandom_range(4095), $urandom_range(15), $urandom_range(65535),
                    idle_pct, 1'b0, '0);
      end else begin
        if (run_left == 0) begin
          k = $urandom_range(7);
          sgn = $urandom_range(1);
          cap = 2 * int'(model_frames) + 4;
          if (cap > 40) cap = 40;
          run_left = $urandom_range(cap, 1);
        end
        lim = int'(model_limit);
        hi = sgn ? 32768 : 32767;
        pick = $urandom_range(99);
        if (pick < 5) mag = 0;
        else if ((pick < 60 || lim == 0) && hi > lim) mag = $urandom_range(hi, lim + 1);
        else mag = $urandom_range(lim, 1);
        send_sample(slot_pool[k], type_pool[k], sgn ? -mag : mag, idle_pct, 1'b0, '0);
        run_left--;
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      n_results++;
      if (flip_to_upper_o) n_up++;
      if (flip_to_lower_o) n_dn++;
      if (pending_results.size() == 0) begin
        flag_mismatch("result with nothing pending", 64'(dwell_value_o), '0);
      end else begin
        expected_now = pending_results.pop_front();
        if (flip_to_upper_o !== expected_now.up)
          flag_mismatch("flip_to_upper", 64'(flip_to_upper_o), 64'(expected_now.up));
        if (flip_to_lower_o !== expected_now.dn)
          flag_mismatch("flip_to_lower", 64'(flip_to_lower_o), 64'(expected_now.dn));
        if (dwell_value_o !== expected_now.dwell)
          flag_mismatch("dwell_value", 64'(dwell_value_o), 64'(expected_now.dwell));
        if (count_to_upper_o !== expected_now.cnt_up)
          flag_mismatch("count_to_upper", 64'(count_to_upper_o), 64'(expected_now.cnt_up));
        if (count_to_lower_o !== expected_now.cnt_dn)
          flag_mismatch("count_to_lower", 64'(count_to_lower_o), 64'(expected_now.cnt_dn));
      end
    end
  end

  initial begin
    int lim_v, fr_v, pct;
    logic [CfgDataW-1:0] cfg_word;

    // settled values after reset, then zone boundaries at the default limit
    add_typed(0, 0, 32767, 1'b0, 1'b0, 11, 0, 0);
    add_typed(0, 0, 0, 1'b0, 1'b0, 11, 0, 0);
    add_typed(4095, 15, -32768, 1'b0, 1'b0, -11, 0, 0);
    add_sample(1, 1, 384);
    add_sample(1, 1, -384);
    add_sample(1, 1, -385);
    add_sample(1, 1, 385);
    add_sample(2, 2, 1);
    add_sample(2, 2, -1);
    add_sample(4095, 15, 32767);
    // two frames, no intermediate zone; upper bits of the data are dropped
    add_write(CfgDwellFrames, 16'hFC02);
    add_write(CfgSpatialLimit, 16'h8000);
    add_sample(7, 5, -100);
    add_sample(7, 5, 100);
    add_typed(7, 5, 100, 1'b1, 1'b0, 2, 1, 0);
    add_sample(7, 5, 100);
    add_sample(7, 5, -100);
    add_typed(7, 5, -100, 1'b0, 1'b1, -2, 1, 1);
    add_write(CfgUnused, 16'h0001);
    add_sample(7, 5, 100);
    // zero dwell frames with the widest limit
    add_write(CfgSpatialLimit, 16'hFFFF);
    add_write(CfgDwellFrames, 16'hFC00);
    add_sample(9, 9, 32767);
    add_sample(9, 9, -32768);
    add_sample(10, 10, 32766);
    add_sample(10, 10, 0);
    add_sample(10, 10, -32767);

    slot_pool[0] = 0;
    slot_pool[1] = 4095;
    for (int i = 2; i < 8; i++) slot_pool[i] = $urandom_range(4095);
    for (int i = 0; i < 8; i++) type_pool[i] = $urandom_range(15);

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == RowWrite) begin
        quiesce();
        write_reg(directed_rows[i].idx, directed_rows[i].data);
      end else begin
        send_sample(directed_rows[i].slot, directed_rows[i].ltype,
                    directed_rows[i].distance, 28, directed_rows[i].typed,
                    directed_rows[i].res);
      end
    end

    for (int p = 0; p < 7; p++) begin
      case (p)
        0: begin lim_v = 384; fr_v = 10; pct = 28; end
        1: begin lim_v = 0; fr_v = 1; pct = 83; end
        2: begin lim_v = 32767; fr_v = 1023; pct = 0; end
        3: begin lim_v = $urandom_range(2000); fr_v = $urandom_range(20, 2); pct = 28; end
        4: begin lim_v = $urandom_range(32767); fr_v = 0; pct = 83; end
        5: begin lim_v = $urandom_range(600, 1); fr_v = $urandom_range(30, 1); pct = 0; end
        default: begin
          lim_v = $urandom_range(32767); fr_v = $urandom_range(1023, 1); pct = 28;
        end
      endcase
      quiesce();
      cfg_word = CfgDataW'($urandom_range(65535));
      cfg_word[LimitW-1:0] = LimitW'(lim_v);
      write_reg(CfgSpatialLimit, cfg_word);
      cfg_word = CfgDataW'($urandom_range(65535));
      cfg_word[FramesW-1:0] = FramesW'(fr_v);
      write_reg(CfgDwellFrames, cfg_word);
      random_phase(215, pct);
    end

    quiesce();
    repeat (8) @(negedge clk_i);

    $display("covered %0d samples over 7 random settings plus a directed table, %0d writes",
             n_results, n_writes);
    $display("flips seen: %0d to upper, %0d to lower", n_up, n_dn);
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results still pending", pending_results.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
